@@ rtl/mexp_pkg.sv @@
package mexp_pkg;

  localparam int unsigned EXP_BITS = 32;
  localparam int unsigned EXP_W = (EXP_BITS < 32) ? EXP_BITS : 32;

  localparam int unsigned RES_W = 30;

  localparam logic [31:0] PRIME = 32'd1000000007;
  localparam logic [31:0] PRIME_X2 = 32'd2000000014;
  localparam logic [31:0] PRIME_X3 = 32'd3000000021;
  localparam logic [31:0] PRIME_X4 = 32'd4000000028;

  localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] MU = MU_FULL[30:0];

  typedef enum logic [1:0] {
    MUL_PROD = 2'd0,
    MUL_QUOT = 2'd1,
    MUL_SUBT = 2'd2
  } mexp_mul_e;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mexp_mul_e mul_op;
    logic      x_sel_sq;
    logic      save_prod;
    logic      wr_red;
    logic      shift_exp;
    logic      res_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
  } mexp_sts_t;

endpackage

@@ rtl/mexp_datapath.sv @@
module mexp_datapath (
  input  logic               clk_i,
  input  logic [31:0]        base_value_i,
  input  logic [31:0]        exponent_i,
  input  mexp_pkg::mexp_cmd_t cmd_i,
  output mexp_pkg::mexp_sts_t sts_o,
  output logic [29:0]        residue_o
);
  import mexp_pkg::*;

  logic [29:0]      acc_q, acc_d;
  logic [29:0]      sq_q, sq_d;
  logic [EXP_W-1:0] exp_q, exp_d;
  logic [61:0]      mul_q;
  logic [31:0]      prod_lo_q;
  logic [29:0]      res_q;

  logic [31:0] base_sub;
  logic [31:0] base_red;
  logic [30:0] mul_a;
  logic [30:0] mul_b;
  logic [29:0] x_op;
  logic [31:0] diff;
  logic [31:0] red;

  always_comb begin
    priority if (base_value_i >= PRIME_X4) begin
      base_sub = PRIME_X4;
    end else if (base_value_i >= PRIME_X3) begin
      base_sub = PRIME_X3;
    end else if (base_value_i >= PRIME_X2) begin
      base_sub = PRIME_X2;
    end else if (base_value_i >= PRIME) begin
      base_sub = PRIME;
    end else begin
      base_sub = 32'd0;
    end
    base_red = base_value_i - base_sub;
  end

  assign x_op = cmd_i.x_sel_sq ? sq_q : acc_q;

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_PROD: begin
        mul_a = {1'b0, x_op};
        mul_b = {1'b0, sq_q};
      end
      MUL_QUOT: begin
        mul_a = mul_q[59:29];
        mul_b = MU;
      end
      MUL_SUBT: begin
        mul_a = mul_q[61:31];
        mul_b = PRIME[30:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The Barrett estimate is at most two short, so the remainder stays below 3P.
  always_comb begin
    diff = prod_lo_q - mul_q[31:0];
    priority if (diff >= PRIME_X2) begin
      red = diff - PRIME_X2;
    end else if (diff >= PRIME) begin
      red = diff - PRIME;
    end else begin
      red = diff;
    end
  end

  always_comb begin
    acc_d = acc_q;
    sq_d  = sq_q;
    exp_d = exp_q;
    if (cmd_i.load) begin
      acc_d = 30'd1;
      sq_d  = base_red[29:0];
      exp_d = exponent_i[EXP_W-1:0];
    end else begin
      if (cmd_i.wr_red) begin
        if (cmd_i.x_sel_sq) begin
          sq_d = red[29:0];
        end else begin
          acc_d = red[29:0];
        end
      end
      if (cmd_i.shift_exp) begin
        exp_d = exp_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sq_q  <= sq_d;
    exp_q <= exp_d;
    if (cmd_i.mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    if (cmd_i.save_prod) begin
      prod_lo_q <= mul_q[31:0];
    end
    if (cmd_i.res_load) begin
      res_q <= acc_q;
    end
  end

  assign sts_o.exp_zero      = (exp_q == '0);
  assign sts_o.exp_lsb       = exp_q[0];
  assign sts_o.exp_rest_zero = ((exp_q >> 1) == '0);
  assign residue_o           = res_q;

endmodule

@@ rtl/mexp_ctrl.sv @@
module mexp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mexp_pkg::mexp_sts_t sts_i,
  output mexp_pkg::mexp_cmd_t cmd_o
);
  import mexp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_PROD  = 7'b0000100,
    ST_QUOT  = 7'b0001000,
    ST_SUBT  = 7'b0010000,
    ST_CORR  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   sqr_q, sqr_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    sqr_d         = sqr_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.mul_op  = MUL_PROD;
    cmd_o.x_sel_sq = sqr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.exp_zero) begin
          state_d = ST_FIN;
        end else begin
          sqr_d   = !sts_i.exp_lsb;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_PROD;
        state_d      = ST_QUOT;
      end
      ST_QUOT: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_op    = MUL_QUOT;
        cmd_o.save_prod = 1'b1;
        state_d         = ST_SUBT;
      end
      ST_SUBT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_SUBT;
        state_d      = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.wr_red = 1'b1;
        if (sqr_q) begin
          cmd_o.shift_exp = 1'b1;
          state_d         = ST_CHECK;
        end else if (sts_i.exp_rest_zero) begin
          state_d = ST_FIN;
        end else begin
          sqr_d   = 1'b1;
          state_d = ST_PROD;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sqr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sqr_q       <= sqr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/modular_exponentiation.sv @@
// Per exponent bit, from the lowest up, a one bit multiplies the accumulator by the square,
// and the square is then squared unless that bit is the highest; a zero exponent gives 1.
// Each modular product makes three passes through one shared 31x31 multiplier
// (product, Barrett quotient, quotient times prime) and then a correction step.
// One transaction is in work at a time; the result register lets the next one start before
// the last result is taken. Reset (rst_ni low, asynchronous) clears the output valid and idles.
module modular_exponentiation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [31:0] base_value, [63:32] exponent
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // [29:0] residue, [31:30] zero
);
  import mexp_pkg::*;

  mexp_cmd_t   cmd;
  mexp_sts_t   sts;
  logic [29:0] residue;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mexp_datapath u_datapath (
    .clk_i        (clk_i),
    .base_value_i (s_axis_tdata_i[31:0]),
    .exponent_i   (s_axis_tdata_i[63:32]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .residue_o    (residue)
  );

  assign m_axis_tdata_o = {2'b00, residue};

endmodule

@@ rtl/mexp_checker.sv @@
module mexp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [63:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Output transaction dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("Output data changed while stalled.");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o < 32'd1000000007))
    else $error("Residue is not reduced below the prime.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Input accepted again while a transaction is in work.");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mexp_pkg::*;

  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] exponent;
    logic [31:0] base_value;
  } operand_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // [31:0] base_value, [63:32] exponent
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // [29:0] residue, [31:30] zero

  operand_t        operand_q[$];
  logic [RES_W-1:0] residue_q[$];
  int unsigned     total_items = 0;
  int unsigned     sent_cnt = 0;
  int unsigned     err_cnt = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     hold_left = 0;
  logic            hold_done = 1'b0;

  modular_exponentiation u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [RES_W-1:0] predict_residue(logic [31:0] b, logic [31:0] e);
    logic [63:0] square;
    logic [63:0] acc;
    logic [31:0] mask;
    logic [31:0] ebits;
    mask = (EXP_W >= 32) ? 32'hFFFF_FFFF : ((32'd1 << EXP_W) - 32'd1);
    ebits = e & mask;
    square = {32'd0, b} % {32'd0, PRIME};
    acc = 64'd1;
    for (int i = 0; i < 32; i++) begin
      if (ebits[i]) begin
        acc = (acc * square) % {32'd0, PRIME};
      end
      square = (square * square) % {32'd0, PRIME};
    end
    return acc[RES_W-1:0];
  endfunction

  function automatic void queue_operand(operand_t op);
    operand_q = {operand_q, op};
  endfunction

  function automatic int unsigned sender_idle_pct(int unsigned n);
    if (n < total_items / 3) return 28;
    if (n < (2 * total_items) / 3) return 82;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct(int unsigned n);
    if (n < total_items / 3) return 82;
    if (n < (2 * total_items) / 3) return 28;
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        residue_q = {residue_q, predict_residue(s_axis_tdata[31:0], s_axis_tdata[63:32])};
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (operand_q.size() != 0 && $urandom_range(99) >= sender_idle_pct(sent_cnt)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= operand_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (residue_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %0d",
                   $time, m_axis_tdata);
          err_cnt <= err_cnt + 1;
        end else if (m_axis_tdata !== {2'b00, residue_q[0]}) begin
          $display("%0t: residue mismatch, expected 0x%08h, actual 0x%08h",
                   $time, {2'b00, residue_q[0]}, m_axis_tdata);
          err_cnt <= err_cnt + 1;
          void'(residue_q.pop_front());
        end else begin
          void'(residue_q.pop_front());
        end
      end
      if (!hold_done && sent_cnt == (5 * total_items) / 6) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct(sent_cnt));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    operand_t    op;
    int unsigned width;
    int unsigned kind;
    logic [31:0] mask;

    queue_operand('{exponent: 32'd0, base_value: 32'd0});
    queue_operand('{exponent: 32'd1, base_value: 32'd0});
    queue_operand('{exponent: 32'hFFFF_FFFF, base_value: 32'hFFFF_FFFF});
    queue_operand('{exponent: 32'd0, base_value: 32'hFFFF_FFFF});
    queue_operand('{exponent: 32'd5, base_value: PRIME});
    queue_operand('{exponent: 32'd0, base_value: PRIME});
    queue_operand('{exponent: 32'hFFFF_FFFF, base_value: PRIME_X4});
    queue_operand('{exponent: 32'd7, base_value: PRIME_X2});
    queue_operand('{exponent: 32'd0, base_value: PRIME_X3});
    queue_operand('{exponent: 32'd2, base_value: PRIME - 32'd1});
    queue_operand('{exponent: 32'hFFFF_FFFE, base_value: PRIME - 32'd1});
    queue_operand('{exponent: 32'd3, base_value: PRIME + 32'd1});
    queue_operand('{exponent: 32'hFFFF_FFFF, base_value: 32'd1});
    queue_operand('{exponent: 32'd1, base_value: 32'hFFFF_FFFF});
    queue_operand('{exponent: 32'd31, base_value: 32'd2});
    queue_operand('{exponent: 32'h8000_0000, base_value: 32'd2});
    queue_operand('{exponent: 32'h5555_5555, base_value: 32'hAAAA_AAAA});
    queue_operand('{exponent: 32'hAAAA_AAAA, base_value: 32'h5555_5555});
    queue_operand('{exponent: 32'hFFFF_FFFE, base_value: 32'd3});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        width = $urandom_range(8);
      end else if (kind < 9) begin
        width = $urandom_range(20, 9);
      end else begin
        width = $urandom_range(32, 21);
      end
      mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
      op.exponent = $urandom & mask;
      kind = $urandom_range(9);
      if (kind < 2) begin
        op.base_value = PRIME * $urandom_range(4) + $urandom_range(3) - 32'd1;
      end else if (kind < 3) begin
        op.base_value = $urandom_range(15);
      end else begin
        op.base_value = $urandom;
      end
      queue_operand(op);
    end
    total_items = operand_q.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (operand_q.size() != 0 || s_axis_tvalid || residue_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
